FILE: rtl/mpfm_pkg.sv
package mpfm_pkg;

  // field widths
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned PER_W    = 8;
  localparam int unsigned RATE_W   = 26;
  localparam int unsigned FREQ_W   = 25;
  localparam int unsigned NUM_W    = RATE_W + PER_W;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // queue between front and back
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  // divider steps, one quotient bit per cycle
  localparam int unsigned DSTEP_W  = $clog2(NUM_W);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIODS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd3;

  // register reset values
  localparam logic [PER_W-1:0]  PERIODS_RST   = 8'd100;
  localparam logic [CNT_W-1:0]  TIMEOUT_RST   = 32'd10000000;
  localparam logic [RATE_W-1:0] TICK_RATE_RST = 26'd20000000;
  localparam logic [FREQ_W-1:0] THRESHOLD_RST = 25'd62920;

  // front phase
  typedef enum logic [1:0] {
    PH_WAIT_LOW  = 2'd0,
    PH_WAIT_HIGH = 2'd1,
    PH_MEASURE   = 2'd2
  } phase_t;

  // back state
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_HOLD = 2'd2
  } back_state_t;

  // one finished measurement handed from front to back
  typedef struct packed {
    logic             no_signal;
    logic [CNT_W-1:0] tick_count;
    logic [NUM_W-1:0] numerator;
  } job_t;

endpackage

FILE: rtl/mpfm_queue.sv
module mpfm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mpfm_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output mpfm_pkg::job_t pop_job
);

  mpfm_pkg::job_t                  mem_r [mpfm_pkg::QDEPTH];
  logic [mpfm_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [mpfm_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [mpfm_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  assign full    = (cnt_r == mpfm_pkg::QCNT_W'(mpfm_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == mpfm_pkg::QPTR_W'(mpfm_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == mpfm_pkg::QPTR_W'(mpfm_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/mpfm_front.sv
module mpfm_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_pin_level,
  input  logic [mpfm_pkg::PER_W-1:0]    periods_to_measure,
  input  logic [mpfm_pkg::CNT_W-1:0]    timeout_ticks,
  input  logic [mpfm_pkg::RATE_W-1:0]   tick_rate_hz,
  input  logic                          q_full,
  output logic                          push,
  output mpfm_pkg::job_t                push_job
);

  mpfm_pkg::phase_t                 phase_r, phase_nxt;
  logic [mpfm_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [mpfm_pkg::PER_W-1:0]       pd_r, pd_nxt;
  logic                             hsl_r, hsl_nxt;
  logic [mpfm_pkg::CNT_W-1:0]       bumped;
  logic                             timeout;
  logic [mpfm_pkg::PER_W-1:0]       target;
  logic [mpfm_pkg::PER_W-1:0]       pd_inc;
  logic [mpfm_pkg::NUM_W-1:0]       numerator;
  logic                             accept;

  // hold off input while a finished result could not be queued
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // saturating tick counter and timeout compare
  assign bumped  = (cnt_r == '1) ? cnt_r : cnt_r + 1'b1;
  assign timeout = (bumped > timeout_ticks);
  assign target  = (periods_to_measure == '0) ? mpfm_pkg::PER_W'(1) : periods_to_measure;
  assign pd_inc  = pd_r + 1'b1;

  // frequency numerator, tick rate times periods
  assign numerator = {{mpfm_pkg::PER_W{1'b0}}, tick_rate_hz} *
                     {{mpfm_pkg::RATE_W{1'b0}}, target};

  // phase sequencing per sampled level
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    pd_nxt    = pd_r;
    hsl_nxt   = hsl_r;
    push      = 1'b0;
    push_job  = '{no_signal: 1'b1, tick_count: '0, numerator: '0};
    if (accept) begin
      unique case (phase_r)
        mpfm_pkg::PH_WAIT_HIGH: begin
          if (in_pin_level) begin
            phase_nxt = mpfm_pkg::PH_MEASURE;
            cnt_nxt   = '0;
            pd_nxt    = '0;
            hsl_nxt   = 1'b0;
          end else begin
            cnt_nxt = bumped;
            push    = timeout;
          end
        end
        mpfm_pkg::PH_MEASURE: begin
          cnt_nxt = bumped;
          if (!hsl_r && !in_pin_level) begin
            hsl_nxt = 1'b1;
          end else if (hsl_r && in_pin_level) begin
            hsl_nxt = 1'b0;
            pd_nxt  = pd_inc;
            if (pd_inc >= target) begin
              push     = 1'b1;
              push_job = '{no_signal: 1'b0, tick_count: bumped, numerator: numerator};
            end
          end else begin
            push = timeout;
          end
        end
        default: begin
          // wait for low, also the unused phase code
          if (!in_pin_level) begin
            phase_nxt = mpfm_pkg::PH_WAIT_HIGH;
            cnt_nxt   = '0;
          end else begin
            phase_nxt = mpfm_pkg::PH_WAIT_LOW;
            cnt_nxt   = bumped;
            push      = timeout;
          end
        end
      endcase
      // a finished measurement restarts from wait for low
      if (push) begin
        phase_nxt = mpfm_pkg::PH_WAIT_LOW;
        cnt_nxt   = '0;
        pd_nxt    = '0;
        hsl_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= mpfm_pkg::PH_WAIT_LOW;
      cnt_r   <= '0;
      pd_r    <= '0;
      hsl_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      pd_r    <= pd_nxt;
      hsl_r   <= hsl_nxt;
    end
  end

endmodule

FILE: rtl/mpfm_back.sv
module mpfm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  mpfm_pkg::job_t                q_job,
  input  logic [mpfm_pkg::FREQ_W-1:0]   threshold_hz,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_no_signal,
  output logic [mpfm_pkg::CNT_W-1:0]    out_tick_count,
  output logic [mpfm_pkg::FREQ_W-1:0]   out_frequency_hz,
  output logic                          out_above_threshold
);

  localparam logic [mpfm_pkg::FREQ_W-1:0] FREQ_MAX = '1;

  mpfm_pkg::back_state_t            state_r, state_nxt;
  logic [mpfm_pkg::DSTEP_W-1:0]     step_r, step_nxt;
  logic [mpfm_pkg::CNT_W-1:0]       div_r, div_nxt;
  logic [mpfm_pkg::CNT_W-1:0]       rem_r, rem_nxt;
  logic [mpfm_pkg::NUM_W-1:0]       quo_r, quo_nxt;
  logic                             nosig_r, nosig_nxt;
  logic [mpfm_pkg::FREQ_W-1:0]      freq_r, freq_nxt;
  logic [mpfm_pkg::FREQ_W-1:0]      last_freq_r, last_freq_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_nosig_r, out_nosig_nxt;
  logic [mpfm_pkg::CNT_W-1:0]       out_cnt_r, out_cnt_nxt;
  logic [mpfm_pkg::FREQ_W-1:0]      out_freq_r, out_freq_nxt;
  logic                             out_above_r, out_above_nxt;
  logic [mpfm_pkg::CNT_W:0]         rem_sh;
  logic [mpfm_pkg::CNT_W:0]         diff;
  logic                             ge;
  logic [mpfm_pkg::NUM_W-1:0]       quo_step;
  logic [mpfm_pkg::FREQ_W-1:0]      freq_eff;
  logic                             slot_free;

  // one restoring division step
  assign rem_sh   = {rem_r, quo_r[mpfm_pkg::NUM_W-1]};
  assign diff     = rem_sh - {1'b0, div_r};
  assign ge       = (rem_sh >= {1'b0, div_r});
  assign quo_step = {quo_r[mpfm_pkg::NUM_W-2:0], ge};

  assign slot_free = !out_valid_r || !out_stall;
  assign freq_eff  = nosig_r ? last_freq_r : freq_r;

  // divider sequencing and output load
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    nosig_nxt     = nosig_r;
    freq_nxt      = freq_r;
    last_freq_nxt = last_freq_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_nosig_nxt = out_nosig_r;
    out_cnt_nxt   = out_cnt_r;
    out_freq_nxt  = out_freq_r;
    out_above_nxt = out_above_r;
    q_pop         = 1'b0;
    unique case (state_r)
      mpfm_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          nosig_nxt = q_job.no_signal;
          div_nxt   = q_job.tick_count;
          rem_nxt   = '0;
          quo_nxt   = q_job.numerator;
          step_nxt  = mpfm_pkg::DSTEP_W'(mpfm_pkg::NUM_W - 1);
          freq_nxt  = '0;
          state_nxt = q_job.no_signal ? mpfm_pkg::BK_HOLD : mpfm_pkg::BK_DIV;
        end
      end
      mpfm_pkg::BK_DIV: begin
        rem_nxt  = ge ? diff[mpfm_pkg::CNT_W-1:0] : rem_sh[mpfm_pkg::CNT_W-1:0];
        quo_nxt  = quo_step;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          // saturate the quotient to the frequency field
          freq_nxt  = (quo_step[mpfm_pkg::NUM_W-1:mpfm_pkg::FREQ_W] != '0) ? FREQ_MAX :
                      quo_step[mpfm_pkg::FREQ_W-1:0];
          state_nxt = mpfm_pkg::BK_HOLD;
        end
      end
      mpfm_pkg::BK_HOLD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nosig_nxt = nosig_r;
          out_cnt_nxt   = nosig_r ? '0 : div_r;
          out_freq_nxt  = freq_r;
          out_above_nxt = (freq_eff > threshold_hz);
          last_freq_nxt = freq_eff;
          state_nxt     = mpfm_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = mpfm_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpfm_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      last_freq_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_freq_r <= last_freq_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    nosig_r     <= nosig_nxt;
    freq_r      <= freq_nxt;
    out_nosig_r <= out_nosig_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_freq_r  <= out_freq_nxt;
    out_above_r <= out_above_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_no_signal       = out_nosig_r;
  assign out_tick_count      = out_cnt_r;
  assign out_frequency_hz    = out_freq_r;
  assign out_above_threshold = out_above_r;

endmodule

FILE: rtl/multi_period_frequency_meter.sv
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   in_pin_level
// out_      output     out_valid / out_stall out_no_signal, out_tick_count,
//                                            out_frequency_hz, out_above_threshold
// cfg_      input      cfg_we                cfg_index, cfg_data
//
// one level sample is taken per cycle while the front queue has room
// a result leaves the back once the 34-step shift-subtract divider has run
// (one quotient bit per cycle); no-signal results skip it
// a two-entry queue sits between front and back; when it is full, in_stall rises
// reset is synchronous on rst_n; no clearing pass, the block is ready right after reset
// out_stall holds the output register; the divider may finish the next result meanwhile
module multi_period_frequency_meter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_pin_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_no_signal,
  output logic [mpfm_pkg::CNT_W-1:0]        out_tick_count,
  output logic [mpfm_pkg::FREQ_W-1:0]       out_frequency_hz,
  output logic                              out_above_threshold,
  input  logic                              cfg_we,
  input  logic [mpfm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mpfm_pkg::CFG_W-1:0]        cfg_data
);

  logic [mpfm_pkg::PER_W-1:0]   periods_r;
  logic [mpfm_pkg::CNT_W-1:0]   timeout_r;
  logic [mpfm_pkg::RATE_W-1:0]  tick_rate_r;
  logic [mpfm_pkg::FREQ_W-1:0]  threshold_r;
  logic                         q_full, q_empty, q_push, q_pop;
  mpfm_pkg::job_t               push_job, pop_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      periods_r   <= mpfm_pkg::PERIODS_RST;
      timeout_r   <= mpfm_pkg::TIMEOUT_RST;
      tick_rate_r <= mpfm_pkg::TICK_RATE_RST;
      threshold_r <= mpfm_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mpfm_pkg::CFG_PERIODS:   periods_r   <= cfg_data[mpfm_pkg::PER_W-1:0];
        mpfm_pkg::CFG_TIMEOUT:   timeout_r   <= cfg_data[mpfm_pkg::CNT_W-1:0];
        mpfm_pkg::CFG_TICK_RATE: tick_rate_r <= cfg_data[mpfm_pkg::RATE_W-1:0];
        mpfm_pkg::CFG_THRESHOLD: threshold_r <= cfg_data[mpfm_pkg::FREQ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sample sequencing
  mpfm_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_pin_level       (in_pin_level),
    .periods_to_measure (periods_r),
    .timeout_ticks      (timeout_r),
    .tick_rate_hz       (tick_rate_r),
    .q_full             (q_full),
    .push               (q_push),
    .push_job           (push_job)
  );

  // finished measurements waiting for the divider
  mpfm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_job  (pop_job)
  );

  // frequency division and result register
  mpfm_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_pop               (q_pop),
    .q_job               (pop_job),
    .threshold_hz        (threshold_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_no_signal       (out_no_signal),
    .out_tick_count      (out_tick_count),
    .out_frequency_hz    (out_frequency_hz),
    .out_above_threshold (out_above_threshold)
  );

endmodule

FILE: sim/multi_period_frequency_meter_test.sv
`timescale 1ns / 100ps

module multi_period_frequency_meter_test;

  localparam int ITEM_TARGET    = 2000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [mpfm_pkg::FREQ_W-1:0] FREQ_TOP = '1;

  typedef struct packed {
    logic                        no_signal;
    logic [mpfm_pkg::CNT_W-1:0]  tick_count;
    logic [mpfm_pkg::FREQ_W-1:0] frequency_hz;
    logic                        above_threshold;
  } meter_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           in_pin_level = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic                           out_no_signal;
  logic [mpfm_pkg::CNT_W-1:0]     out_tick_count;
  logic [mpfm_pkg::FREQ_W-1:0]    out_frequency_hz;
  logic                           out_above_threshold;
  logic                           cfg_we = 1'b0;
  logic [mpfm_pkg::CFG_IDX_W-1:0] cfg_index = mpfm_pkg::CFG_PERIODS;
  logic [mpfm_pkg::CFG_W-1:0]     cfg_data = '0;

  // register copies as the meter sees them
  logic [mpfm_pkg::PER_W-1:0]  cfg_periods   = mpfm_pkg::PERIODS_RST;
  logic [mpfm_pkg::CNT_W-1:0]  cfg_timeout   = mpfm_pkg::TIMEOUT_RST;
  logic [mpfm_pkg::RATE_W-1:0] cfg_rate      = mpfm_pkg::TICK_RATE_RST;
  logic [mpfm_pkg::FREQ_W-1:0] cfg_threshold = mpfm_pkg::THRESHOLD_RST;

  // measurement state of the predictor
  mpfm_pkg::phase_t            meter_phase  = mpfm_pkg::PH_WAIT_LOW;
  logic [mpfm_pkg::CNT_W-1:0]  tick_cnt     = '0;
  logic [mpfm_pkg::PER_W-1:0]  periods_seen = '0;
  logic                        saw_low      = 1'b0;
  logic [mpfm_pkg::FREQ_W-1:0] last_freq    = '0;

  logic          pending_levels[$];
  meter_result_t expected_results[$];
  meter_result_t want;

  int   send_idle_pct = 36;
  int   recv_idle_pct = 81;
  logic hold_request = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;
  int   mismatches = 0;
  int   items_queued = 0;
  int   samples_accepted = 0;
  int   results_checked = 0;
  int   no_signal_count = 0;
  int   settings_used = 0;

  multi_period_frequency_meter u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pin_level        (in_pin_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_no_signal       (out_no_signal),
    .out_tick_count      (out_tick_count),
    .out_frequency_hz    (out_frequency_hz),
    .out_above_threshold (out_above_threshold),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // saturating tick counter
  function automatic void bump_ticks();
    if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
  endfunction

  // queue one finished measurement and restart from wait for low
  function automatic void end_measurement(input logic nosig,
                                          input logic [mpfm_pkg::CNT_W-1:0] cnt,
                                          input logic [mpfm_pkg::FREQ_W-1:0] freq);
    meter_result_t res;
    res.no_signal       = nosig;
    res.tick_count      = cnt;
    res.frequency_hz    = freq;
    res.above_threshold = (last_freq > cfg_threshold);
    expected_results.push_back(res);
    meter_phase  = mpfm_pkg::PH_WAIT_LOW;
    tick_cnt     = '0;
    periods_seen = '0;
    saw_low      = 1'b0;
  endfunction

  // advance the meter by one sampled level
  function automatic void step_meter(input logic level);
    logic [mpfm_pkg::PER_W-1:0] target;
    logic [63:0]                quot;
    logic                       timed_out;
    timed_out = 1'b0;
    target = (cfg_periods == '0) ? mpfm_pkg::PER_W'(1) : cfg_periods;
    case (meter_phase)
      mpfm_pkg::PH_WAIT_HIGH: begin
        if (level) begin
          meter_phase  = mpfm_pkg::PH_MEASURE;
          tick_cnt     = '0;
          periods_seen = '0;
          saw_low      = 1'b0;
        end else begin
          bump_ticks();
          timed_out = (tick_cnt > cfg_timeout);
        end
      end
      mpfm_pkg::PH_MEASURE: begin
        bump_ticks();
        if (!saw_low && !level) begin
          saw_low = 1'b1;
        end else if (saw_low && level) begin
          // rising edge closes a period
          saw_low = 1'b0;
          periods_seen = periods_seen + 1'b1;
          if (periods_seen >= target) begin
            quot = (64'(cfg_rate) * 64'(target)) / 64'(tick_cnt);
            last_freq = (quot > 64'(FREQ_TOP)) ? FREQ_TOP : quot[mpfm_pkg::FREQ_W-1:0];
            end_measurement(1'b0, tick_cnt, last_freq);
          end
        end else begin
          timed_out = (tick_cnt > cfg_timeout);
        end
      end
      default: begin
        if (!level) begin
          meter_phase = mpfm_pkg::PH_WAIT_HIGH;
          tick_cnt    = '0;
        end else begin
          bump_ticks();
          timed_out = (tick_cnt > cfg_timeout);
        end
      end
    endcase
    if (timed_out) end_measurement(1'b1, '0, '0);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_val,
                                      input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_pin_level <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_meter(in_pin_level);
        samples_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_levels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid     <= 1'b1;
          in_pin_level <= pending_levels.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("no_signal", 64'(want.no_signal), 64'(out_no_signal));
          check_field("tick_count", 64'(want.tick_count), 64'(out_tick_count));
          check_field("frequency_hz", 64'(want.frequency_hz), 64'(out_frequency_hz));
          check_field("above_threshold", 64'(want.above_threshold),
                      64'(out_above_threshold));
          results_checked++;
          if (want.no_signal) no_signal_count++;
        end
      end
      // long hold-off counted here once requested
      if (hold_request) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      out_stall <= hold_request || (hold_left > 1) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_run(input logic level, input int n);
    repeat (n) begin
      pending_levels.push_back(level);
      items_queued++;
    end
  endtask

  // square wave: low lead-in, rising edge, then full periods
  task automatic queue_wave(input int periods, input int max_half);
    push_run(1'b0, $urandom_range(1, max_half));
    push_run(1'b1, $urandom_range(1, max_half));
    repeat (periods) begin
      push_run(1'b0, $urandom_range(1, max_half));
      push_run(1'b1, $urandom_range(1, max_half));
    end
  endtask

  // mostly waves, some noise and flat runs that trip the timeouts
  task automatic queue_random_traffic(input int n, input int max_half);
    int first;
    int pick;
    int per_eff;
    first = items_queued;
    per_eff = (cfg_periods == '0) ? 1 : int'(cfg_periods);
    while (items_queued - first < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        queue_wave($urandom_range(1, per_eff), max_half);
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 10)) push_run(1'($urandom_range(0, 1)), 1);
      end else begin
        push_run(1'($urandom_range(0, 1)), $urandom_range(1, 70));
      end
    end
  endtask

  // sender waits for every result, then the divider gets time to settle
  task automatic drain_results();
    while (pending_levels.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mpfm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mpfm_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      mpfm_pkg::CFG_PERIODS:   cfg_periods   = val[mpfm_pkg::PER_W-1:0];
      mpfm_pkg::CFG_TIMEOUT:   cfg_timeout   = val[mpfm_pkg::CNT_W-1:0];
      mpfm_pkg::CFG_TICK_RATE: cfg_rate      = val[mpfm_pkg::RATE_W-1:0];
      default:                 cfg_threshold = val[mpfm_pkg::FREQ_W-1:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input logic [mpfm_pkg::PER_W-1:0] per,
                                input logic [mpfm_pkg::CNT_W-1:0] tmo,
                                input logic [mpfm_pkg::RATE_W-1:0] rate,
                                input logic [mpfm_pkg::FREQ_W-1:0] thr);
    drain_results();
    write_reg(mpfm_pkg::CFG_PERIODS, mpfm_pkg::CFG_W'(per));
    write_reg(mpfm_pkg::CFG_TIMEOUT, mpfm_pkg::CFG_W'(tmo));
    write_reg(mpfm_pkg::CFG_TICK_RATE, mpfm_pkg::CFG_W'(rate));
    write_reg(mpfm_pkg::CFG_THRESHOLD, mpfm_pkg::CFG_W'(thr));
    settings_used++;
  endtask

  // idling schedule by progress through the run
  task automatic pick_idling();
    if (items_queued < 700) begin
      send_idle_pct = 36;
      recv_idle_pct = 81;
    end else if (items_queued < 1400) begin
      send_idle_pct = 81;
      recv_idle_pct = 36;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  initial begin : stimulus
    logic [mpfm_pkg::RATE_W-1:0] rnd_rate;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one full measurement under the reset settings
    queue_wave(int'(mpfm_pkg::PERIODS_RST), 2);

    // directed: shortest period, each wait timing out, zero periods
    apply_settings(8'd1, 32'd3, 26'd40000000, 25'd0);
    push_run(1'b0, 1);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    push_run(1'b1, 1);
    push_run(1'b1, 4);
    push_run(1'b0, 5);
    push_run(1'b0, 1);
    push_run(1'b1, 5);
    apply_settings(8'd0, 32'd3, 26'd40000000, 25'd0);
    push_run(1'b0, 1);
    push_run(1'b1, 1);
    push_run(1'b0, 1);
    push_run(1'b1, 1);

    // longest measurement, no timeout possible, slowest rate, top threshold
    pick_idling();
    apply_settings(8'd255, 32'hFFFF_FFFF, 26'd1, FREQ_TOP);
    queue_wave(255, 1);
    repeat (20) push_run(1'($urandom_range(0, 1)), 1);

    // timeout of a single tick
    apply_settings(8'd1, 32'd1, 26'd40000000, 25'd20000000);
    queue_random_traffic(150, 2);

    // receiver holds off while back-to-back measurements fill the queue
    apply_settings(8'd1, 32'd20, 26'd12345678, 25'($urandom_range(0, 3000000)));
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    repeat (40) queue_wave(1, 1);

    // random settings and traffic
    while (items_queued < ITEM_TARGET) begin
      drain_results();
      pick_idling();
      rnd_rate = mpfm_pkg::RATE_W'($urandom_range(1, 40000000));
      apply_settings(mpfm_pkg::PER_W'($urandom_range(1, 6)),
                     mpfm_pkg::CNT_W'($urandom_range(8, 60)), rnd_rate,
                     mpfm_pkg::FREQ_W'($urandom_range(0, rnd_rate / 4)));
      queue_random_traffic(60, $urandom_range(1, 6));
      drain_results();
      queue_random_traffic(60, $urandom_range(1, 6));
    end

    drain_results();
    $display("covered %0d level samples, %0d results (%0d with no signal)",
             samples_accepted, results_checked, no_signal_count);
    $display("across %0d register settings, with stalls and idles on both sides",
             settings_used);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
